[design/bpq_pkg.sv]
// bucket priority queue: shared command and status codes
// used by the channel interfaces, the sequencer core and the top level
package bpq_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_POP    = 2'd1,
      CMD_DELETE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

[design/bpq_if.sv]
// bucket priority queue: request and response channel interfaces
// valid/ready handshake; uses bpq_pkg for the command and status codes
interface bpq_req_if #(
   parameter int NODE_W = 12,
   parameter int KEY_W  = 13
);
   logic                 valid;
   logic                 ready;
   bpq_pkg::cmd_type     cmd;
   logic [NODE_W-1:0]    node_id;
   logic [KEY_W-1:0]     score_key;

   modport source (output valid, cmd, node_id, score_key, input ready);
   modport sink   (input valid, cmd, node_id, score_key, output ready);
endinterface

interface bpq_rsp_if #(
   parameter int NODE_W = 12,
   parameter int CNT_W  = 13
);
   logic                 valid;
   logic                 ready;
   logic [NODE_W-1:0]    out_node;
   bpq_pkg::status_type  status;
   logic [CNT_W-1:0]     entry_count;

   modport source (output valid, out_node, status, entry_count, input ready);
   modport sink   (input valid, out_node, status, entry_count, output ready);
endinterface

[design/bpq_ram.sv]
// generic simple dual port ram: one write port, one registered read port
// no dependencies
module bpq_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 8192,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/bpq_core.sv]
// bucket priority queue sequencer: bucket head and link memories
// driven by a small state machine; uses bpq_pkg, bpq_ram
module bpq_core #(
   parameter int NUM_BUCKETS = 8192,
   parameter int NUM_NODES   = 4096,
   localparam int KEY_W  = $clog2(NUM_BUCKETS),
   localparam int NODE_W = $clog2(NUM_NODES),
   localparam int CNT_W  = $clog2(NUM_NODES + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  bpq_pkg::cmd_type    cmd,
   input  logic [NODE_W-1:0]   node_id,
   input  logic [KEY_W-1:0]    score_key,
   input  logic                out_free,
   output logic                idle,
   output logic                done,
   output logic [NODE_W-1:0]   out_node,
   output bpq_pkg::status_type status,
   output logic [CNT_W-1:0]    entry_count
);

   localparam int HEAD_W = NODE_W + 1;
   localparam logic [KEY_W-1:0]  KEY_LAST = KEY_W'(NUM_BUCKETS - 1);
   localparam logic [KEY_W:0]    KEY_LIM  = (KEY_W + 1)'(NUM_BUCKETS);
   localparam logic [NODE_W:0]   NODE_LIM = (NODE_W + 1)'(NUM_NODES);
   localparam logic [CNT_W-1:0]  CNT_LIM  = CNT_W'(NUM_NODES);

   typedef enum logic [3:0] {
      CLEAR, IDLE, DISPATCH, INS_WR, POP_SCAN, POP_LINK,
      DEL_HEAD, DEL_UNHEAD, DEL_WALK, DEL_SPLICE, DONE
   } state_type;

   state_type           state_ff, state_in;
   bpq_pkg::cmd_type    cmd_ff, cmd_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    min_key_ff, min_key_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [KEY_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [KEY_W-1:0]    scan_addr_ff, scan_addr_in;
   logic [KEY_W-1:0]    data_key_ff, data_key_in;
   logic                data_ok_ff, data_ok_in;
   logic [NODE_W-1:0]   prev_ff, prev_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [NODE_W-1:0]   res_node_ff, res_node_in;
   bpq_pkg::status_type res_status_ff, res_status_in;

   logic                head_we;
   logic [KEY_W-1:0]    head_waddr, head_raddr;
   logic [HEAD_W-1:0]   head_wdata, head_rdata;
   logic                link_we;
   logic [NODE_W-1:0]   link_waddr, link_raddr;
   logic [HEAD_W-1:0]   link_wdata, link_rdata;

   // word layout in both memories: valid bit on top of the node number
   bpq_ram #(.WIDTH(HEAD_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   bpq_ram #(.WIDTH(HEAD_W), .DEPTH(NUM_NODES)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      node_in       = node_ff;
      key_in        = key_ff;
      min_key_in    = min_key_ff;
      count_in      = count_ff;
      clr_addr_in   = clr_addr_ff;
      scan_addr_in  = scan_addr_ff;
      data_key_in   = data_key_ff;
      data_ok_in    = data_ok_ff;
      prev_in       = prev_ff;
      steps_in      = steps_ff;
      res_node_in   = res_node_ff;
      res_status_in = res_status_ff;
      head_we       = 1'b0;
      head_waddr    = key_ff;
      head_wdata    = '0;
      head_raddr    = key_ff;
      link_we       = 1'b0;
      link_waddr    = node_ff;
      link_wdata    = head_rdata;
      link_raddr    = node_ff;
      done          = 1'b0;

      case (state_ff)
         CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_addr_ff;
            head_wdata = '0;
            clr_addr_in = clr_addr_ff + KEY_W'(1);
            if (clr_addr_ff == KEY_LAST) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               node_in  = node_id;
               key_in   = score_key;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            res_node_in   = '0;
            res_status_in = bpq_pkg::ST_OK;
            case (cmd_ff)
               bpq_pkg::CMD_INSERT: begin
                  if ({1'b0, node_ff} >= NODE_LIM || {1'b0, key_ff} >= KEY_LIM
                      || count_ff >= CNT_LIM) begin
                     res_status_in = bpq_pkg::ST_FULL;
                     state_in      = DONE;
                  end else begin
                     state_in = INS_WR;
                  end
               end
               bpq_pkg::CMD_POP: begin
                  if (count_ff == '0) begin
                     res_status_in = bpq_pkg::ST_EMPTY;
                     state_in      = DONE;
                  end else begin
                     scan_addr_in = min_key_ff;
                     data_ok_in   = 1'b0;
                     state_in     = POP_SCAN;
                  end
               end
               bpq_pkg::CMD_DELETE: begin
                  if ({1'b0, node_ff} >= NODE_LIM || {1'b0, key_ff} >= KEY_LIM) begin
                     res_status_in = bpq_pkg::ST_NOT_FOUND;
                     state_in      = DONE;
                  end else begin
                     state_in = DEL_HEAD;
                  end
               end
               default: begin
                  state_in = DONE;
               end
            endcase
         end
         INS_WR: begin
            // push at chain head: old head becomes the new node's link
            link_we    = 1'b1;
            link_waddr = node_ff;
            link_wdata = head_rdata;
            head_we    = 1'b1;
            head_waddr = key_ff;
            head_wdata = {1'b1, node_ff};
            count_in   = count_ff + CNT_W'(1);
            if (key_ff < min_key_ff) begin
               min_key_in = key_ff;
            end
            state_in = DONE;
         end
         POP_SCAN: begin
            // one bucket read issued per cycle, its data checked in the following cycle
            head_raddr  = scan_addr_ff;
            data_key_in = scan_addr_ff;
            data_ok_in  = 1'b1;
            if (scan_addr_ff != KEY_LAST) begin
               scan_addr_in = scan_addr_ff + KEY_W'(1);
            end
            if (data_ok_ff && head_rdata[NODE_W]) begin
               min_key_in = data_key_ff;
               key_in     = data_key_ff;
               prev_in    = head_rdata[NODE_W-1:0];
               link_raddr = head_rdata[NODE_W-1:0];
               state_in   = POP_LINK;
            end else if (data_ok_ff && data_key_ff == KEY_LAST) begin
               min_key_in    = KEY_LAST;
               res_status_in = bpq_pkg::ST_EMPTY;
               state_in      = DONE;
            end
         end
         POP_LINK: begin
            head_we     = 1'b1;
            head_waddr  = key_ff;
            head_wdata  = link_rdata;
            count_in    = count_ff - CNT_W'(1);
            res_node_in = prev_ff;
            state_in    = DONE;
         end
         DEL_HEAD: begin
            if (!head_rdata[NODE_W]) begin
               res_status_in = bpq_pkg::ST_NOT_FOUND;
               state_in      = DONE;
            end else if (head_rdata[NODE_W-1:0] == node_ff) begin
               link_raddr = node_ff;
               state_in   = DEL_UNHEAD;
            end else begin
               prev_in    = head_rdata[NODE_W-1:0];
               steps_in   = '0;
               link_raddr = head_rdata[NODE_W-1:0];
               state_in   = DEL_WALK;
            end
         end
         DEL_UNHEAD: begin
            head_we    = 1'b1;
            head_waddr = key_ff;
            head_wdata = link_rdata;
            if (count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = DONE;
         end
         DEL_WALK: begin
            // link_rdata holds the successor of prev
            if (!link_rdata[NODE_W] || steps_ff >= CNT_LIM) begin
               res_status_in = bpq_pkg::ST_NOT_FOUND;
               state_in      = DONE;
            end else if (link_rdata[NODE_W-1:0] == node_ff) begin
               link_raddr = node_ff;
               state_in   = DEL_SPLICE;
            end else begin
               prev_in    = link_rdata[NODE_W-1:0];
               steps_in   = steps_ff + CNT_W'(1);
               link_raddr = link_rdata[NODE_W-1:0];
            end
         end
         DEL_SPLICE: begin
            link_we    = 1'b1;
            link_waddr = prev_ff;
            link_wdata = link_rdata;
            if (count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
            end
            state_in = DONE;
         end
         DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CLEAR;
         clr_addr_ff <= '0;
         min_key_ff  <= KEY_LAST;
         count_ff    <= '0;
         data_ok_ff  <= 1'b0;
         steps_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         min_key_ff  <= min_key_in;
         count_ff    <= count_in;
         data_ok_ff  <= data_ok_in;
         steps_ff    <= steps_in;
      end
      cmd_ff        <= cmd_in;
      node_ff       <= node_in;
      key_ff        <= key_in;
      scan_addr_ff  <= scan_addr_in;
      data_key_ff   <= data_key_in;
      prev_ff       <= prev_in;
      res_node_ff   <= res_node_in;
      res_status_ff <= res_status_in;
   end

   assign idle        = (state_ff == IDLE);
   assign out_node    = res_node_ff;
   assign status      = res_status_ff;
   assign entry_count = count_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_LIM)
      else $error("queued count above node capacity");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      start && idle |=> state_ff == DISPATCH)
      else $error("accepted item not dispatched");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> ($past(state_ff) == INS_WR || $past(state_ff) == POP_LINK
                              || $past(state_ff) == DEL_UNHEAD
                              || $past(state_ff) == DEL_SPLICE))
      else $error("queued count changed outside a commit state");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= CNT_LIM)
      else $error("delete walk ran past its bound");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> idle)
      else $error("sequencer not idle after handing off a result");

endmodule

[design/bucket_priority_queue.sv]
// bucket priority queue top level: request/response channels, result register
// uses bpq_pkg, bpq_if (bpq_req_if, bpq_rsp_if) and bpq_core
//
//   channel    dir   contents                               handshake
//   req_chan   in    cmd, node_id, score_key                valid/ready
//   rsp_chan   out   out_node, status, entry_count          valid/ready
//
// one item at a time; every item yields exactly one response item
// insert: dispatch, then the head and link write; refused insert: dispatch only
// pop: if empty dispatch only, else a scan up from the minimum key, then an unlink
// delete: dispatch, a head check, then a head unlink or a chain walk and a splice
// after reset a clearing pass over the bucket heads runs before any item is taken
// a new item is taken while the previous response waits in the output register
module bucket_priority_queue #(
   parameter int NUM_BUCKETS = 8192,
   parameter int NUM_NODES   = 4096
) (
   input logic        clock,
   input logic        reset,
   bpq_req_if.sink    req_chan,
   bpq_rsp_if.source  rsp_chan
);

   localparam int KEY_W  = $clog2(NUM_BUCKETS);
   localparam int NODE_W = $clog2(NUM_NODES);
   localparam int CNT_W  = $clog2(NUM_NODES + 1);

   logic                core_idle;
   logic                core_done;
   logic                out_free;
   logic                req_accept;
   logic [NODE_W-1:0]   core_node;
   bpq_pkg::status_type core_status;
   logic [CNT_W-1:0]    core_count;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]   rsp_node_ff;
   bpq_pkg::status_type rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   // sequencer only takes an item when it sits idle
   assign req_chan.ready = core_idle;
   assign req_accept     = req_chan.valid && core_idle;

   // result may land when the slot is empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   bpq_core #(
      .NUM_BUCKETS (NUM_BUCKETS),
      .NUM_NODES   (NUM_NODES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .cmd         (req_chan.cmd),
      .node_id     (req_chan.node_id),
      .score_key   (req_chan.score_key),
      .out_free    (out_free),
      .idle        (core_idle),
      .done        (core_done),
      .out_node    (core_node),
      .status      (core_status),
      .entry_count (core_count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload only loads with a fresh result
      if (core_done) begin
         rsp_node_ff   <= core_node;
         rsp_status_ff <= core_status;
         rsp_count_ff  <= core_count;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_node    = rsp_node_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule

[tb/testbench.sv]
// testbench for bucket_priority_queue: directed table, mixed random traffic and a
// final drain; responses checked against an in-bench queue model or typed answers
// depends on bpq_pkg, bpq_if (bpq_req_if, bpq_rsp_if) and bucket_priority_queue
module testbench;

   localparam int NUM_BUCKETS    = 8192;
   localparam int NUM_NODES      = 4096;
   localparam int RANDOM_ITEMS   = 500;
   localparam int MAX_WAIT       = 18;
   localparam int LONG_HOLD      = 300;     // one long receiver stall
   localparam int WATCHDOG_LIMIT = 50000;   // full bucket scan or clearing pass, several times
   localparam int DRAIN_CYCLES   = 40;

   // one response as the queue should report it
   typedef struct {
      logic [11:0]         node;
      bpq_pkg::status_type status;
      logic [12:0]         count;
      int                  tag;
   } queue_answer_type;

   // one row of the directed table; fixed rows carry their answer typed in
   typedef struct {
      bpq_pkg::cmd_type    cmd;
      logic [11:0]         node;
      logic [12:0]         key;
      bit                  fixed;
      logic [11:0]         exp_node;
      bpq_pkg::status_type exp_status;
      logic [12:0]         exp_count;
   } directed_row_type;

   logic clock;
   logic reset;

   bpq_req_if req_bus ();
   bpq_rsp_if rsp_bus ();

   bucket_priority_queue u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // ---------------------------------------------------------------------------
   // queue model: bucket heads, per-node links, minimum key and occupancy
   // ---------------------------------------------------------------------------
   logic [11:0] head_node [NUM_BUCKETS];
   bit          head_live [NUM_BUCKETS];
   logic [11:0] link_node [NUM_NODES];
   bit          link_live [NUM_NODES];
   logic [12:0] lowest_key;
   logic [12:0] node_total;

   // answers still owed by the block, oldest first
   queue_answer_type pending_answers [$];

   // stimulus-side view of which nodes sit in the queue, and under which key
   bit          on_queue   [NUM_NODES];
   logic [12:0] queued_key [NUM_NODES];
   int          live_ids [$];

   directed_row_type script [$];

   int  items_sent;
   int  results_seen;
   int  mismatches;
   int  quiet_cycles;
   int  hold_gaps;
   bit  send_calm;
   bit  long_hold_pending;
   int  n_insert, n_full, n_pop, n_empty, n_delete, n_absent, n_nop;
   int  peak_count;

   // work out the answer to one request and update the model state
   function automatic queue_answer_type apply_queue_op(bpq_pkg::cmd_type cmd,
                                                       logic [11:0] node, logic [12:0] key);
      queue_answer_type ans;
      int               k;
      int               steps;
      logic [11:0]      prev;
      logic [11:0]      cur;
      bit               found;
      ans.node   = '0;
      ans.status = bpq_pkg::ST_OK;
      ans.tag    = 0;
      found      = 1'b0;
      case (cmd)
         bpq_pkg::CMD_INSERT: begin
            if (node_total >= NUM_NODES) begin
               ans.status = bpq_pkg::ST_FULL;
            end else begin
               // push on the head of the key's chain
               link_node[node] = head_node[key];
               link_live[node] = head_live[key];
               head_node[key]  = node;
               head_live[key]  = 1'b1;
               node_total++;
               if (key < lowest_key) lowest_key = key;
            end
         end
         bpq_pkg::CMD_POP: begin
            if (node_total == 0) begin
               ans.status = bpq_pkg::ST_EMPTY;
            end else begin
               // scan upward from the minimum key to the first live bucket
               k = lowest_key;
               while (k < NUM_BUCKETS && !head_live[k]) k++;
               if (k >= NUM_BUCKETS) begin
                  // count says nodes but every bucket is empty
                  lowest_key = NUM_BUCKETS - 1;
                  ans.status = bpq_pkg::ST_EMPTY;
               end else begin
                  lowest_key   = 13'(k);
                  ans.node     = head_node[k];
                  head_node[k] = link_node[ans.node];
                  head_live[k] = link_live[ans.node];
                  node_total--;
               end
            end
         end
         bpq_pkg::CMD_DELETE: begin
            if (!head_live[key]) begin
               ans.status = bpq_pkg::ST_NOT_FOUND;
            end else if (head_node[key] == node) begin
               head_node[key] = link_node[node];
               head_live[key] = link_live[node];
               found          = 1'b1;
            end else begin
               // walk the chain, giving up after one link per node
               prev  = head_node[key];
               steps = 0;
               cur   = '0;
               while (!found && link_live[prev] && steps < NUM_NODES) begin
                  cur = link_node[prev];
                  if (cur == node) begin
                     found = 1'b1;
                  end else begin
                     prev = cur;
                     steps++;
                  end
               end
               if (found) begin
                  link_node[prev] = link_node[cur];
                  link_live[prev] = link_live[cur];
               end else begin
                  ans.status = bpq_pkg::ST_NOT_FOUND;
               end
            end
            if (found && node_total > 0) node_total--;
         end
         default: ;
      endcase
      ans.count = node_total;
      return ans;
   endfunction

   function automatic void forget_node(logic [11:0] node);
      on_queue[node] = 1'b0;
      foreach (live_ids[i]) begin
         if (live_ids[i] == node) begin
            live_ids.delete(i);
            break;
         end
      end
   endfunction

   // keep the stimulus view of the queue and the run statistics in step
   function automatic void record_outcome(bpq_pkg::cmd_type cmd, logic [11:0] node,
                                          logic [12:0] key, queue_answer_type ans);
      case (cmd)
         bpq_pkg::CMD_INSERT: begin
            n_insert++;
            if (ans.status == bpq_pkg::ST_FULL) begin
               n_full++;
            end else if (!on_queue[node]) begin
               on_queue[node]   = 1'b1;
               queued_key[node] = key;
               live_ids.push_back(node);
            end
         end
         bpq_pkg::CMD_POP: begin
            n_pop++;
            if (ans.status == bpq_pkg::ST_EMPTY) n_empty++;
            else forget_node(ans.node);
         end
         bpq_pkg::CMD_DELETE: begin
            n_delete++;
            if (ans.status == bpq_pkg::ST_NOT_FOUND) n_absent++;
            else forget_node(node);
         end
         default: n_nop++;
      endcase
      if (ans.count > peak_count) peak_count = ans.count;
   endfunction

   function automatic void add_step(bpq_pkg::cmd_type cmd, int node, int key,
                                    bit fixed = 1'b0, int exp_node = 0,
                                    bpq_pkg::status_type exp_status = bpq_pkg::ST_OK,
                                    int exp_count = 0);
      directed_row_type row;
      row.cmd        = cmd;
      row.node       = 12'(node);
      row.key        = 13'(key);
      row.fixed      = fixed;
      row.exp_node   = 12'(exp_node);
      row.exp_status = exp_status;
      row.exp_count  = 13'(exp_count);
      script.push_back(row);
   endfunction

   task automatic flag_mismatch(int tag, string what);
      mismatches++;
      $display("MISMATCH item %0d: %s", tag, what);
   endtask

   // ---------------------------------------------------------------------------
   // request side: optional idle gap, then hold the item until it is taken
   // ---------------------------------------------------------------------------
   task automatic send_op(bpq_pkg::cmd_type cmd, logic [11:0] node, logic [12:0] key,
                          queue_answer_type want);
      int gap;
      // switch between busy and gap-free stretches every few dozen items
      if (items_sent % 32 == 0) send_calm = ($urandom_range(3) == 0);
      if (hold_gaps > 0) begin
         hold_gaps--;
         gap = 0;
      end else begin
         gap = send_calm ? 0 : $urandom_range(MAX_WAIT);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.node_id   <= node;
      req_bus.score_key <= key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      want.tag = items_sent;
      pending_answers.push_back(want);
      items_sent++;
   endtask

   task automatic issue(bpq_pkg::cmd_type cmd, logic [11:0] node, logic [12:0] key);
      queue_answer_type ans;
      ans = apply_queue_op(cmd, node, key);
      record_outcome(cmd, node, key, ans);
      send_op(cmd, node, key, ans);
   endtask

   // drop valid and wait until every owed answer has come back
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // ---------------------------------------------------------------------------
   // clock and stimulus
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      queue_answer_type ans;
      int               pick;
      logic [11:0]      node;
      logic [12:0]      key;
      logic [12:0]      key_base;

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= bpq_pkg::CMD_NOP;
      req_bus.node_id   <= '0;
      req_bus.score_key <= '0;
      lowest_key        = NUM_BUCKETS - 1;
      node_total        = '0;
      key_base          = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table; the block is still clearing buckets, so the first item waits
      // empty right after reset
      add_step(bpq_pkg::CMD_POP, 0, 0, 1'b1, 0, bpq_pkg::ST_EMPTY, 0);
      // delete from empty bucket
      add_step(bpq_pkg::CMD_DELETE, 5, 5, 1'b1, 0, bpq_pkg::ST_NOT_FOUND, 0);
      // unused command
      add_step(bpq_pkg::CMD_NOP, 4095, 8191, 1'b1, 0, bpq_pkg::ST_OK, 0);
      // top node, top key
      add_step(bpq_pkg::CMD_INSERT, 4095, 8191, 1'b1, 0, bpq_pkg::ST_OK, 1);
      // bottom node, bottom key
      add_step(bpq_pkg::CMD_INSERT, 0, 0, 1'b1, 0, bpq_pkg::ST_OK, 2);
      add_step(bpq_pkg::CMD_INSERT, 2730, 0, 1'b1, 0, bpq_pkg::ST_OK, 3);
      // chain of three at key 0
      add_step(bpq_pkg::CMD_INSERT, 1365, 0, 1'b1, 0, bpq_pkg::ST_OK, 4);
      // chain ends without node
      add_step(bpq_pkg::CMD_DELETE, 77, 0, 1'b1, 0, bpq_pkg::ST_NOT_FOUND, 4);
      add_step(bpq_pkg::CMD_DELETE, 2730, 0);                 // unlink from mid chain
      add_step(bpq_pkg::CMD_POP, 4095, 8191);                 // pop ignores its fields
      add_step(bpq_pkg::CMD_POP, 0, 0);
      add_step(bpq_pkg::CMD_POP, 0, 0);                       // scans the whole key range
      add_step(bpq_pkg::CMD_INSERT, 1365, 5461);
      // right node, wrong key
      add_step(bpq_pkg::CMD_DELETE, 1365, 2730, 1'b1, 0, bpq_pkg::ST_NOT_FOUND, 1);
      add_step(bpq_pkg::CMD_DELETE, 1365, 5461);
      // insert a queued node again so a chain is cut off: count outlives the nodes
      add_step(bpq_pkg::CMD_INSERT, 100, 5);
      add_step(bpq_pkg::CMD_INSERT, 200, 5);
      add_step(bpq_pkg::CMD_INSERT, 200, 6);
      add_step(bpq_pkg::CMD_POP, 0, 0);
      add_step(bpq_pkg::CMD_POP, 0, 0);
      // count without nodes
      add_step(bpq_pkg::CMD_POP, 0, 0, 1'b1, 0, bpq_pkg::ST_EMPTY, 1);
      // node linked to itself: the delete walk has to give up
      add_step(bpq_pkg::CMD_INSERT, 300, 9);
      add_step(bpq_pkg::CMD_INSERT, 300, 9);
      add_step(bpq_pkg::CMD_DELETE, 301, 9, 1'b1, 0, bpq_pkg::ST_NOT_FOUND, 3);
      add_step(bpq_pkg::CMD_DELETE, 300, 9);
      add_step(bpq_pkg::CMD_DELETE, 300, 9);
      add_step(bpq_pkg::CMD_DELETE, 300, 9);                  // count reaches zero
      // break the loop and clear both buckets; the last delete must not underflow
      add_step(bpq_pkg::CMD_INSERT, 300, 10);
      add_step(bpq_pkg::CMD_DELETE, 300, 9);
      add_step(bpq_pkg::CMD_DELETE, 300, 10);

      foreach (script[i]) begin
         ans = apply_queue_op(script[i].cmd, script[i].node, script[i].key);
         record_outcome(script[i].cmd, script[i].node, script[i].key, ans);
         if (script[i].fixed) begin
            ans.node   = script[i].exp_node;
            ans.status = script[i].exp_status;
            ans.count  = script[i].exp_count;
         end
         send_op(script[i].cmd, script[i].node, script[i].key, ans);
      end
      settle();

      // the directed part leaves the queue empty; start the random part from a clean view
      foreach (on_queue[i]) on_queue[i] = 1'b0;
      live_ids.delete();

      // random part: mostly inserts of free nodes and deletes of queued ones,
      // keys clustered in a moving window so chains form and pops scan
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) key_base = 13'($urandom_range(NUM_BUCKETS - 1));
         if (i == 150) begin
            // receiver stalls for a long stretch while requests keep coming
            long_hold_pending = 1'b1;
            hold_gaps         = 40;
         end
         if (i == 350) settle();   // let the queue answer everything, then resume
         pick = $urandom_range(99);
         key  = ($urandom_range(9) < 7) ? 13'(key_base + $urandom_range(63))
                                        : 13'($urandom_range(NUM_BUCKETS - 1));
         if (pick < 40) begin
            do node = 12'($urandom_range(NUM_NODES - 1)); while (on_queue[node]);
            issue(bpq_pkg::CMD_INSERT, node, key);
         end else if (pick < 68) begin
            issue(bpq_pkg::CMD_POP, 12'($urandom_range(NUM_NODES - 1)), key);
         end else if (pick < 92) begin
            if (live_ids.size() > 0 && $urandom_range(4) != 0) begin
               node = 12'(live_ids[$urandom_range(live_ids.size() - 1)]);
               issue(bpq_pkg::CMD_DELETE, node, queued_key[node]);
            end else begin
               // mostly absent: walks whatever chain sits at the key
               issue(bpq_pkg::CMD_DELETE, 12'($urandom_range(NUM_NODES - 1)), key);
            end
         end else begin
            issue(bpq_pkg::CMD_NOP, 12'($urandom_range(NUM_NODES - 1)),
                  13'($urandom_range(NUM_BUCKETS - 1)));
         end
      end

      // drain what is left by pops and deletes of queued nodes
      while (live_ids.size() > 0) begin
         if ($urandom_range(9) < 7) begin
            issue(bpq_pkg::CMD_POP, 12'($urandom_range(NUM_NODES - 1)),
                  13'($urandom_range(NUM_BUCKETS - 1)));
         end else begin
            node = 12'(live_ids[$urandom_range(live_ids.size() - 1)]);
            issue(bpq_pkg::CMD_DELETE, node, queued_key[node]);
         end
      end
      issue(bpq_pkg::CMD_POP, '0, '0);
      settle();

      // quiet tail: any late extra response shows up as unexpected
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d requests: %0d inserts (%0d refused), %0d pops (%0d empty),",
               items_sent, n_insert, n_full, n_pop, n_empty);
      $display("  %0d deletes (%0d not found), %0d no-ops; %0d responses, peak %0d, %0d bad",
               n_delete, n_absent, n_nop, results_seen, peak_count, mismatches);
      if (mismatches == 0) begin
         $display("bucket_priority_queue: match");
      end else begin
         $display("bucket_priority_queue: mismatch");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // response side: random stalls per item, one long stall on request
   // ---------------------------------------------------------------------------
   initial begin
      int wait_cycles;
      int served;
      bit calm;
      served        = 0;
      calm          = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         if (long_hold_pending) begin
            wait_cycles       = LONG_HOLD;
            long_hold_pending = 1'b0;
         end else begin
            wait_cycles = calm ? 0 : $urandom_range(MAX_WAIT);
         end
         if (wait_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1 || reset);
         served++;
         if (served % 32 == 0) calm = ($urandom_range(3) == 0);
      end
   end

   // ---------------------------------------------------------------------------
   // response check: oldest owed answer, field by field
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      queue_answer_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         results_seen++;
         if (pending_answers.size() == 0) begin
            flag_mismatch(-1, $sformatf("unexpected response: node %0d status %0d count %0d",
                                        rsp_bus.out_node, rsp_bus.status,
                                        rsp_bus.entry_count));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_bus.out_node !== want.node)
               flag_mismatch(want.tag, $sformatf("out_node %0d, expected %0d",
                                                 rsp_bus.out_node, want.node));
            if (rsp_bus.status !== want.status)
               flag_mismatch(want.tag, $sformatf("status %0d, expected %s",
                                                 rsp_bus.status, want.status.name()));
            if (rsp_bus.entry_count !== want.count)
               flag_mismatch(want.tag, $sformatf("entry_count %0d, expected %0d",
                                                 rsp_bus.entry_count, want.count));
         end
      end
   end

   // watchdog: too long with no item moving on either channel
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no item moved for %0d cycles, %0d responses outstanding",
                  quiet_cycles, pending_answers.size());
         $display("bucket_priority_queue: mismatch");
         $finish;
      end
   end

endmodule
